// ===== design/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, widths and character codes for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int CHAR_W  = 8;
   localparam int LEN_W   = 13;
   localparam int SEXT_W  = 6;
   localparam int ACC_W   = 12;
   localparam int HELD_W  = 4;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3d;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2f;
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [SEXT_W-1:0] SEXT_LOWER = 6'd26;
   localparam logic [SEXT_W-1:0] SEXT_DIGIT = 6'd52;
   localparam logic [SEXT_W-1:0] SEXT_PLUS  = 6'd62;
   localparam logic [SEXT_W-1:0] SEXT_SLASH = 6'd63;

   localparam logic [HELD_W-1:0] BYTE_BITS  = 4'd8;
   localparam logic [HELD_W-1:0] SEXT_BITS  = 4'd6;

   typedef struct packed {
      logic              ok;
      logic [SEXT_W-1:0] val;
   } sextet_type;

   typedef struct packed {
      logic [LEN_W-1:0]  decoded_length;
      logic              text_done;
      logic              byte_valid;
      logic [CHAR_W-1:0] data_byte;
   } rsp_word_type;

   function automatic sextet_type sextet_of(input logic [CHAR_W-1:0] c);
      sextet_type s;
      logic [CHAR_W-1:0] d;
      s.ok  = 1'b1;
      s.val = '0;
      d     = '0;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
         d     = c - CHAR_UP_A;
         s.val = d[SEXT_W-1:0];
      end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
         d     = c - CHAR_LO_A;
         s.val = d[SEXT_W-1:0] + SEXT_LOWER;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d     = c - CHAR_ZERO;
         s.val = d[SEXT_W-1:0] + SEXT_DIGIT;
      end else if (c == CHAR_PLUS) begin
         s.val = SEXT_PLUS;
      end else if (c == CHAR_SLASH) begin
         s.val = SEXT_SLASH;
      end else begin
         s.ok  = 1'b0;
      end
      return s;
   endfunction

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

endpackage

// ===== design/base64_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Decodes a base64 character stream into bytes, one character per cycle while req_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one character per word. tdata[7:0] is the character,
//   tdata[20:8] the byte limit for the current string; tlast marks the last
//   character of a string.
//   rsp channel: a word comes out when a byte is kept or a string ends.
//   tdata[7:0] is the byte (zero when none), tdata[20:8] the count of bytes
//   kept so far, tuser says a byte is present, tlast marks end of string.
//   Each word is registered in the output buffer before rsp_tvalid. Throughput
//   is one character per cycle while req_tready is high; the decode state
//   updates in the cycle a word is accepted, so there is no dependency stall.
//   A two-entry output buffer sits on the rsp side: outside reset, req_tready
//   drops only when both entries hold words. A stall on rsp lets one more
//   word in, then req_tready stays low through the cycle in which the
//   receiver takes a word.
//   Reset (synchronous, active high) clears the decode state and empties
//   the output buffer; req_tready is low while reset is asserted.
//   Bytes past the smaller of the word's limit and MAX_PAYLOAD are dropped.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
   parameter int MAX_PAYLOAD = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] in_char, [20:8] length_limit, [23:21] zero
   input  logic [b64d_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] data_byte, [20:8] decoded_length, [23:21] zero
   output logic [b64d_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] byte_valid
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import b64d_pkg::*;

   localparam int LenMaxInt = (1 << LEN_W) - 1;
   localparam int CapInt    = (MAX_PAYLOAD > LenMaxInt) ? LenMaxInt : MAX_PAYLOAD;
   localparam logic [LEN_W-1:0] MaxCap = LEN_W'(CapInt);

   logic [ACC_W-1:0]  acc_ff,   acc_in;
   logic [HELD_W-1:0] held_ff,  held_in;
   logic              pad_ff,   pad_in;
   logic [LEN_W-1:0]  kept_ff,  kept_in;

   rsp_word_type out_ff, out_in, skid_ff, skid_in;
   logic         out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic              accept, take, push;
   logic [CHAR_W-1:0] in_char;
   logic [LEN_W-1:0]  length_limit, eff_limit;
   sextet_type        sext;
   logic [ACC_W-1:0]  acc_new;
   logic [HELD_W-1:0] held_sum, held_new;
   logic [CHAR_W-1:0] byte_new;
   logic              have_byte;
   rsp_word_type      word_new;

   assign in_char      = req_tdata[CHAR_W-1:0];
   assign length_limit = req_tdata[CHAR_W +: LEN_W];
   assign eff_limit    = (length_limit > MaxCap) ? MaxCap : length_limit;

   assign req_tready = !skid_valid_ff && !reset;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   // decode one character against the current state
   always_comb begin
      sext      = sextet_of(in_char);
      acc_new   = {acc_ff[ACC_W-SEXT_W-1:0], sext.val};
      held_sum  = held_ff + SEXT_BITS;
      held_new  = (held_sum >= BYTE_BITS) ? held_sum - BYTE_BITS : held_sum;
      case (held_new)
         4'd0:    byte_new = acc_new[7:0];
         4'd2:    byte_new = acc_new[9:2];
         4'd4:    byte_new = acc_new[11:4];
         default: byte_new = '0;
      endcase

      acc_in    = acc_ff;
      held_in   = held_ff;
      pad_in    = pad_ff;
      kept_in   = kept_ff;
      have_byte = 1'b0;

      if (!pad_ff && !is_blank(in_char)) begin
         if (in_char == CHAR_PAD) begin
            pad_in = 1'b1;
         end else if (sext.ok) begin
            acc_in  = acc_new;
            held_in = held_new;
            if (held_sum >= BYTE_BITS && kept_ff < eff_limit) begin
               have_byte = 1'b1;
               kept_in   = kept_ff + LEN_W'(1);
            end
         end
      end

      word_new.data_byte      = have_byte ? byte_new : '0;
      word_new.byte_valid     = have_byte;
      word_new.text_done      = req_tlast;
      word_new.decoded_length = kept_in;

      // end of string clears everything after the result is formed
      if (req_tlast) begin
         acc_in  = '0;
         held_in = '0;
         pad_in  = 1'b0;
         kept_in = '0;
      end

      push = accept && (have_byte || req_tlast);
   end

   // two-entry output buffer
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push && out_valid_ff && !take) begin
         skid_in       = word_new;
         skid_valid_in = 1'b1;
      end else if (push) begin
         out_in       = word_new;
         out_valid_in = 1'b1;
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         held_ff       <= '0;
         pad_ff        <= 1'b0;
         kept_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            acc_ff  <= acc_in;
            held_ff <= held_in;
            pad_ff  <= pad_in;
            kept_ff <= kept_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-CHAR_W-LEN_W)'(0), out_ff.decoded_length,
                        out_ff.data_byte};
   assign rsp_tuser  = out_ff.byte_valid;
   assign rsp_tlast  = out_ff.text_done;

endmodule

// ===== design/b64d_checker.sv =====
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks for the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [b64d_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);
   import b64d_pkg::*;

   // output buffer is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word present after reset");

   // a word without a byte only comes for an end of string
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("rsp word with no byte and no tlast");

   // no byte means a zero data field
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[CHAR_W-1:0] == '0)
      else $error("data byte not zero on empty word");

   // a kept byte always counts itself
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[CHAR_W +: LEN_W] != '0)
      else $error("byte word with zero length");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);
